// File: rtl/core/bppf_pkg.sv
// shared types and constants for the byte pattern position finder
// no dependencies; imported by every module of the block
package bppf_pkg;

  localparam int unsigned MaxPatternDefault   = 16;
  localparam int unsigned PositionWidthDefault = 32;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned PatBytesW = 128;
  localparam int unsigned PatLenW   = 5;
  localparam int unsigned LimitW    = 32;
  localparam int unsigned OutPosW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW  = 8'd0,
    CFG_PAT_HIGH = 8'd1,
    CFG_PAT_LEN  = 8'd2,
    CFG_LIMIT    = 8'd3
  } bppf_cfg_idx_e;

  typedef struct packed {
    logic [PatBytesW-1:0] pattern;
    logic [PatLenW-1:0]   length;
    logic [LimitW-1:0]    limit;
  } bppf_cfg_t;

  typedef struct packed {
    logic [OutPosW-1:0] position;
    logic               found;
    logic               done;
  } bppf_result_t;

endpackage

// File: rtl/core/byte_pattern_position_finder.sv
// byte pattern position finder top level
// depends on bppf_pkg, bppf_cfg_regs, bppf_matcher, bppf_skid
//
// Input stream s_axis carries one byte per word, tlast on the final byte of
// a stream. Output stream m_axis carries a word whenever a pattern occurrence
// ends at the accepted byte (tuser high, tdata = 1-based start position) or
// the byte is the last of its stream (tlast high, tdata zero if no match).
// Bytes that produce neither give no output word.
// The cfg channel writes pattern bytes, pattern length and match limit by
// register index; it is always ready and should be written while idle.
// Each output word is registered in bppf_skid before it appears on m_axis.
// Throughput: one byte per cycle while tready is high; the compare over the whole
// pattern window and the position counter update complete in that single cycle.
// When m_axis stalls, one more word is held in a skid register and s_axis
// tready drops until that register drains.
// Reset clears the window, both counters and the output valid flags, and sets
// pattern length to 1, the match limit to all ones, pattern bytes to zero.
module byte_pattern_position_finder import bppf_pkg::*; #(
  parameter int unsigned MAX_PATTERN    = MaxPatternDefault,
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // match_position
  output logic                m_axis_tuser,   // match_found
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  bppf_cfg_t    cfg;
  bppf_result_t result, out_word;
  logic         accept, has_result;

  assign accept = s_axis_tvalid && s_axis_tready;

  bppf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bppf_matcher #(
    .MAX_PATTERN    (MAX_PATTERN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  bppf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && has_result),
    .data_i      (result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_word)
  );

  assign m_axis_tdata = out_word.position;
  assign m_axis_tuser = out_word.found;
  assign m_axis_tlast = out_word.done;

endmodule

// File: rtl/core/bppf_cfg_regs.sv
// configuration register file: pattern bytes, pattern length, match limit
// depends on bppf_pkg
module bppf_cfg_regs import bppf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output bppf_cfg_t           cfg_o
);

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [PatLenW-1:0]  pat_len_q;
  logic [LimitW-1:0]   limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= PatLenW'(1);
      limit_q    <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[PatLenW-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern = {pat_high_q, pat_low_q};
  assign cfg_o.length  = pat_len_q;
  assign cfg_o.limit   = limit_q;

endmodule

// File: rtl/core/bppf_matcher.sv
// byte window, parallel pattern compare and per-stream position counters
// depends on bppf_pkg
module bppf_matcher import bppf_pkg::*; #(
  parameter int unsigned MAX_PATTERN    = MaxPatternDefault,
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  input  bppf_cfg_t    cfg_i,
  output logic         has_result_o,
  output bppf_result_t result_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned ExtW = (POSITION_WIDTH > OutPosW) ? POSITION_WIDTH : OutPosW;

  logic [MAX_PATTERN-1:0][7:0] win_q, win_d;
  logic [POSITION_WIDTH-1:0]   seen_q, seen_d, seen_inc, pos;
  logic [LimitW-1:0]           matches_q, matches_d;
  logic [LenW-1:0]             len;
  logic [LenW-1:0]             tap;
  logic [IdxW-1:0]             idx;
  logic                        counted, eq, found;
  logic [ExtW-1:0]             pos_ext;

  always_comb begin
    if (cfg_i.length == '0) begin
      len = LenW'(1);
    end else if (32'(cfg_i.length) > MAX_PATTERN) begin
      len = LenW'(MAX_PATTERN);
    end else begin
      len = LenW'(cfg_i.length);
    end
  end

  always_comb begin
    win_d[0] = byte_i;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  always_comb begin
    eq  = 1'b1;
    tap = '0;
    idx = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tap = LenW'(len - LenW'(1) - LenW'(k));
      idx = tap[IdxW-1:0];
      if (LenW'(k) < len && win_d[idx] != cfg_i.pattern[8*k +: 8]) begin
        eq = 1'b0;
      end
    end
  end

  assign counted  = (seen_q != '1);
  assign seen_inc = seen_q + POSITION_WIDTH'(1);
  assign found    = counted && (seen_inc >= POSITION_WIDTH'(len)) &&
                    (matches_q < cfg_i.limit) && eq;
  assign pos      = seen_inc - POSITION_WIDTH'(len) + POSITION_WIDTH'(1);
  assign pos_ext  = ExtW'(pos);

  always_comb begin
    if (last_i) begin
      seen_d    = '0;
      matches_d = '0;
    end else begin
      seen_d    = counted ? seen_inc : seen_q;
      matches_d = found ? matches_q + LimitW'(1) : matches_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      seen_q    <= '0;
      matches_q <= '0;
    end else if (accept_i) begin
      win_q     <= last_i ? '0 : win_d;
      seen_q    <= seen_d;
      matches_q <= matches_d;
    end
  end

  assign has_result_o      = found || last_i;
  assign result_o.position = found ? pos_ext[OutPosW-1:0] : '0;
  assign result_o.found    = found;
  assign result_o.done     = last_i;

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> (seen_q == '0 && matches_q == '0))
    else $error("stream end did not clear counters");
  a_seen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !last_i && seen_q != '1) |=> (seen_q == $past(seen_q) + POSITION_WIDTH'(1)))
    else $error("byte counter did not advance");
  a_found_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> (seen_inc >= POSITION_WIDTH'(len) && pos != '0))
    else $error("match reported before pattern fits in stream");
`endif

endmodule

// File: rtl/core/bppf_skid.sv
// result register with a skid stage so one more word is taken while output stalls
// depends on bppf_pkg
module bppf_skid import bppf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  bppf_result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output bppf_result_t data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  bppf_result_t out_q, out_d;
  bppf_result_t skid_q, skid_d;
  logic         pop, load_out;

  assign pop      = out_valid_q && pop_ready_i;
  assign load_out = !out_valid_q || pop;
  assign ready_o  = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (load_out) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !ready_o)
    else $error("ready while skid is occupied");
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !pop_ready_i) |=> skid_valid_q)
    else $error("word lost during output stall");
`endif

endmodule

// File: test/tb_byte_pattern_position_finder.sv
// testbench for byte_pattern_position_finder: random and directed byte streams
// checked against a local predictor of the window compare and position counters
// depends on bppf_pkg and the rtl top level only
module tb_byte_pattern_position_finder import bppf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1850;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned IdleLimit   = 2000;

  typedef struct packed {
    logic [7:0] data_b;
    logic       last_b;
  } stream_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  bppf_cfg_idx_e        cfg_index_i = CFG_PAT_LOW;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // predictor state and its copy of the registers
  logic [7:0]   win_q [16];
  logic [31:0]  seen_cnt;
  logic [31:0]  hit_cnt;
  logic [127:0] cfg_pattern = '0;
  logic [4:0]   cfg_length = 5'd1;
  logic [31:0]  cfg_limit = '1;

  stream_word_t byte_q [$];
  bppf_result_t result_q [$];

  int unsigned n_pushed = 0;
  int unsigned n_bytes_in = 0;
  int unsigned n_streams = 0;
  int unsigned n_words = 0;
  int unsigned n_match_words = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_errors = 0;

  int unsigned tx_gap = 0;
  bit          tx_burst = 1'b0;
  int unsigned rx_wait = 0;
  bit          rx_burst = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned idle_cycles = 0;
  stream_word_t tx_next;
  bppf_result_t rx_got;
  bppf_result_t rx_want;

  byte_pattern_position_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned eff_len();
    if (cfg_length == 0) return 1;
    if (cfg_length > MaxPatternDefault) return MaxPatternDefault;
    return 32'(cfg_length);
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < 16; k++) win_q[k] = 8'h00;
    seen_cnt = '0;
    hit_cnt = '0;
  endfunction

  function automatic void predict_word(logic [7:0] data_b, logic last_b);
    int unsigned span;
    logic        counted;
    logic        hit;
    logic [31:0] pos;
    span = eff_len();
    for (int k = 15; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = data_b;
    counted = (seen_cnt != '1);
    if (counted) seen_cnt++;
    hit = 1'b0;
    pos = '0;
    if (counted && seen_cnt >= span && hit_cnt < cfg_limit) begin
      hit = 1'b1;
      for (int k = 0; k < span; k++)
        if (win_q[span-1-k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        pos = seen_cnt - span + 1;
        hit_cnt++;
      end
    end
    if (last_b) clear_window();
    if (hit || last_b) result_q.push_back({pos, hit, last_b});
  endfunction

  function automatic void note_mismatch(string what, bppf_result_t want, bppf_result_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%s: expected pos=%0d found=%0b done=%0b, got pos=%0d found=%0b done=%0b",
               what, want.position, want.found, want.done, got.position, got.found, got.done);
  endfunction

  function automatic void push_word(logic [7:0] data_b, logic last_b);
    byte_q.push_back({data_b, last_b});
    n_pushed++;
  endfunction

  // mix of whole and cut-off pattern copies, pattern bytes and noise
  function automatic void push_stream(int unsigned nbytes);
    logic [7:0]  seq_q [$];
    int unsigned span;
    int unsigned cut;
    int unsigned r;
    span = eff_len();
    while (seq_q.size() < nbytes) begin
      r = $urandom_range(0, 7);
      if (r < 4) begin
        cut = (r == 0) ? $urandom_range(1, span) : span;
        for (int k = 0; k < cut; k++) seq_q.push_back(cfg_pattern[8*k +: 8]);
      end else if (r < 6) begin
        seq_q.push_back(cfg_pattern[8*$urandom_range(0, span-1) +: 8]);
      end else begin
        seq_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (seq_q.size() > nbytes) void'(seq_q.pop_back());
    foreach (seq_q[k]) push_word(seq_q[k], k == nbytes - 1);
  endfunction

  task automatic cfg_write(bppf_cfg_idx_e idx, logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PAT_LOW:  cfg_pattern[63:0] = d;
      CFG_PAT_HIGH: cfg_pattern[127:64] = d;
      CFG_PAT_LEN:  cfg_length = d[4:0];
      CFG_LIMIT:    cfg_limit = d[31:0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic set_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_d,
                            logic [63:0] lim_d);
    @(posedge clk_i);
    cfg_write(CFG_PAT_LOW, lo);
    cfg_write(CFG_PAT_HIGH, hi);
    cfg_write(CFG_PAT_LEN, len_d);
    cfg_write(CFG_LIMIT, lim_d);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tdata, s_axis_tlast);
        n_bytes_in++;
        if (s_axis_tlast) n_streams++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          tx_next = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_next.data_b;
          s_axis_tlast  <= tx_next.last_b;
          if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
        n_words++;
        if (rx_got.found) n_match_words++;
        if (result_q.size() == 0) begin
          note_mismatch("unexpected word", '0, rx_got);
        end else begin
          rx_want = result_q.pop_front();
          if (rx_got.position !== rx_want.position || rx_got.found !== rx_want.found ||
              rx_got.done !== rx_want.done)
            note_mismatch("mismatch", rx_want, rx_got);
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = LongHold;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IdleLimit) begin
          $display("timeout: no word moved for %0d cycles", IdleLimit);
          $display("tb_byte_pattern_position_finder: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [31:0] lim;
    logic [7:0]  sym0;
    logic [7:0]  sym1;
    bit          first_random;
    clear_window();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: pattern 00, length 1, no limit
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b1);
    wait_idle();

    // length zero acts as one, limit zero with upper data bits set
    set_config(64'h0000_0000_0000_00FF, 64'h0, 64'h0, 64'hFFFF_FFFF_0000_0000);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b1);
    wait_idle();

    // overlapping hits cut off by the limit, short stream gives no hit
    set_config(64'h0000_0000_0000_5A5A, 64'h0, 64'd2, 64'd2);
    push_word(8'h5A, 1'b1);
    for (int k = 0; k < 4; k++) push_word(8'h5A, k == 3);
    wait_idle();

    // length above 16 saturates, full 16 byte pattern ending on the last byte
    set_config(64'h5AA5_8001_7FFE_FF00, 64'h817E_AA55_CC33_F00F, 64'hFFFF_FFFF_FFFF_FFF1,
               64'h0000_0000_FFFF_FFFF);
    for (int k = 0; k < 16; k++) push_word(cfg_pattern[8*k +: 8], k == 15);
    wait_idle();

    first_random = 1'b1;
    while (n_pushed < RandomItems + 26) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
        sym0 = 8'($urandom);
        sym1 = 8'($urandom);
        for (int k = 0; k < 8; k++) begin
          lo[8*k +: 8] = $urandom_range(0, 1) ? sym0 : sym1;
          hi[8*k +: 8] = $urandom_range(0, 1) ? sym0 : sym1;
        end
      end
      case ($urandom_range(0, 7))
        0:       len = 5'd0;
        1:       len = 5'($urandom_range(17, 31));
        2:       len = 5'd16;
        3, 4:    len = 5'($urandom_range(1, 4));
        default: len = 5'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 3))
        0:       lim = $urandom_range(0, 4);
        1:       lim = $urandom;
        default: lim = '1;
      endcase
      if (first_random) begin
        len = 5'd1;
        lim = '1;
      end
      set_config(lo, hi, {32'($urandom), 27'($urandom), len}, {32'($urandom), lim});
      if (first_random) begin
        // receiver holds off while the sender keeps going
        rx_hold_req = 1'b1;
        for (int k = 0; k < 3; k++) push_stream(40);
        first_random = 1'b0;
      end else begin
        repeat ($urandom_range(1, 6))
          push_stream(($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 48));
      end
      wait_idle();
    end

    $display("covered %0d bytes in %0d streams with %0d register writes",
             n_bytes_in, n_streams, n_cfg_writes);
    $display("checked %0d result words, %0d of them matches, %0d mismatches",
             n_words, n_match_words, n_errors);
    if (n_errors == 0) begin
      $display("tb_byte_pattern_position_finder: PASS");
    end else begin
      $display("tb_byte_pattern_position_finder: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bppf_pkg.sv
rtl/core/bppf_cfg_regs.sv
rtl/core/bppf_matcher.sv
rtl/core/bppf_skid.sv
rtl/core/byte_pattern_position_finder.sv
test/tb_byte_pattern_position_finder.sv
